@@ hw/rtl/wcct_pkg.sv @@
package wcct_pkg;
   localparam int COORD_BITS_DEF = 12;
   localparam int SIZE_BITS = 13;
   localparam int WEIGHT_BITS = 40;
   localparam int SUM_BITS = 64;
   localparam int THR_BITS = 20;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 20;
   localparam logic [9:0] HIT_WEIGHT = 10'd765;
   localparam logic [4:0] GROW_BIG = 5'd15;
   localparam logic [4:0] GROW_BIG2 = 5'd30;

   localparam logic [CSR_IDX_BITS-1:0] REG_MASK_THR = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_HUE_CTR  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_HUE_TOL  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_WIN      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_W  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_H  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_WEIGHT   = 3'd6;

   typedef struct packed {
      logic accum;      // accumulate the pixel held at the request port
      logic div_start;  // begin both centroid divisions
      logic finish;     // update region and point, clear accumulators
   } ctrl_cmd_type;

   typedef struct packed {
      logic frame_end;
      logic div_done;
   } ctrl_sts_type;
endpackage

@@ hw/rtl/wcct_ctrl.sv @@
module wcct_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  wcct_pkg::ctrl_sts_type sts,
   output wcct_pkg::ctrl_cmd_type cmd
);
   import wcct_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_FIN  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      take;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign take = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accum = take;
            if (take && sts.frame_end) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (sts.div_done) begin
               cmd.finish = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

@@ hw/rtl/wcct_dp.sv @@
module wcct_dp #(
   parameter int COORD_BITS = wcct_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [wcct_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [wcct_pkg::CSR_DATA_BITS-1:0] csr_write_data,
   input  logic [COORD_BITS-1:0]         col,
   input  logic [COORD_BITS-1:0]         row,
   input  logic [7:0]                    chan_blue,
   input  logic [7:0]                    chan_green,
   input  logic [7:0]                    chan_red,
   input  logic [7:0]                    hue_value,
   input  logic                          frame_end,
   input  wcct_pkg::ctrl_cmd_type        cmd,
   output wcct_pkg::ctrl_sts_type        sts,
   output logic                          found,
   output logic [COORD_BITS-1:0]         point_x,
   output logic [COORD_BITS-1:0]         point_y,
   output logic [COORD_BITS-1:0]         region_x,
   output logic [COORD_BITS-1:0]         region_y,
   output logic [wcct_pkg::SIZE_BITS-1:0] region_width,
   output logic [wcct_pkg::SIZE_BITS-1:0] region_height
);
   import wcct_pkg::*;

   localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);
   localparam int SB = SIZE_BITS + 2;
   localparam int RB = SB + 1;
   localparam int PB = COORD_BITS + 10;

   logic [7:0]  mask_thr_ff, hue_ctr_ff, hue_tol_ff;
   logic [SIZE_BITS-1:0] win_ff, fw_ff, fh_ff;
   logic [THR_BITS-1:0] wthr_ff;

   logic [SUM_BITS-1:0] sum_c_ff, sum_r_ff;
   logic [WEIGHT_BITS-1:0] wt_ff;
   logic hit_ff;
   logic [COORD_BITS-1:0] left_ff, top_ff, px_ff, py_ff;
   logic [SIZE_BITS-1:0] sw_ff, sh_ff;
   logic found_ff;

   // Two restoring dividers run side by side, one quotient bit a cycle each.
   logic [SUM_BITS-1:0] qc_ff, qr_ff;
   logic [WEIGHT_BITS:0] remc_ff, remr_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_thr_ff <= 8'd70;
         hue_ctr_ff <= 8'd120;
         hue_tol_ff <= 8'd10;
         win_ff <= SIZE_BITS'(64);
         fw_ff <= SIZE_BITS'(640);
         fh_ff <= SIZE_BITS'(480);
         wthr_ff <= THR_BITS'(3000);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_MASK_THR: mask_thr_ff <= csr_write_data[7:0];
            REG_HUE_CTR:  hue_ctr_ff <= csr_write_data[7:0];
            REG_HUE_TOL:  hue_tol_ff <= csr_write_data[7:0];
            REG_WIN:      win_ff <= csr_write_data[SIZE_BITS-1:0];
            REG_FRAME_W:  fw_ff <= csr_write_data[SIZE_BITS-1:0];
            REG_FRAME_H:  fh_ff <= csr_write_data[SIZE_BITS-1:0];
            REG_WEIGHT:   wthr_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Pixel qualification.
   logic in_region, colour_ok, qualify, fits;
   logic signed [9:0] hue_s, hi_s, lo_s;
   logic [WEIGHT_BITS-1:0] w_add;
   logic [WEIGHT_BITS:0] wt_sum;

   always_comb begin
      in_region = (RB'(col) >= RB'(left_ff)) &&
                  (RB'(col) < (RB'(left_ff) + RB'(sw_ff))) &&
                  (RB'(row) >= RB'(top_ff)) &&
                  (RB'(row) < (RB'(top_ff) + RB'(sh_ff)));
      hue_s = $signed({2'b0, hue_value});
      hi_s = $signed({2'b0, hue_ctr_ff}) + $signed({2'b0, hue_tol_ff});
      lo_s = $signed({2'b0, hue_ctr_ff}) - $signed({2'b0, hue_tol_ff});
      colour_ok = (chan_blue > mask_thr_ff) && (chan_green > mask_thr_ff) &&
                  (chan_red > mask_thr_ff) && (hue_s < hi_s) && (hue_s > lo_s);
      w_add = hit_ff ? WEIGHT_BITS'(HIT_WEIGHT) : WEIGHT_BITS'(1);
      wt_sum = {1'b0, wt_ff} + {1'b0, w_add};
      fits = !wt_sum[WEIGHT_BITS];
      qualify = in_region && colour_ok && fits;
   end

   logic [SUM_BITS-1:0] col_w, row_w;
   always_comb begin
      col_w = hit_ff ? SUM_BITS'(PB'(col) * PB'(HIT_WEIGHT)) : SUM_BITS'(col);
      row_w = hit_ff ? SUM_BITS'(PB'(row) * PB'(HIT_WEIGHT)) : SUM_BITS'(row);
   end

   logic [WEIGHT_BITS:0] tc, tr;
   always_comb begin
      tc = {remc_ff[WEIGHT_BITS-1:0], qc_ff[SUM_BITS-1]};
      tr = {remr_ff[WEIGHT_BITS-1:0], qr_ff[SUM_BITS-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (cmd.div_start) begin
         busy_ff <= 1'b1;
         cnt_ff <= DIV_CNT_BITS'(SUM_BITS);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         qc_ff <= sum_c_ff;
         qr_ff <= sum_r_ff;
         remc_ff <= '0;
         remr_ff <= '0;
      end else if (busy_ff) begin
         if (tc >= {1'b0, wt_ff}) begin
            remc_ff <= tc - {1'b0, wt_ff};
            qc_ff <= {qc_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            remc_ff <= tc;
            qc_ff <= {qc_ff[SUM_BITS-2:0], 1'b0};
         end
         if (tr >= {1'b0, wt_ff}) begin
            remr_ff <= tr - {1'b0, wt_ff};
            qr_ff <= {qr_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            remr_ff <= tr;
            qr_ff <= {qr_ff[SUM_BITS-2:0], 1'b0};
         end
      end
   end

   assign sts.frame_end = frame_end;
   assign sts.div_done = !busy_ff;

   // Frame-end decision.
   logic det;
   logic [COORD_BITS-1:0] npx, npy, nleft, ntop, gleft, gtop;
   logic [SIZE_BITS-1:0] gw, gh;

   function automatic logic [COORD_BITS-1:0] centre(
      input logic [COORD_BITS-1:0] p, input logic [SIZE_BITS-1:0] lim,
      input logic [SIZE_BITS-1:0] win);
      logic signed [SB:0] half, v;
      begin
         half = $signed((SB+1)'(win >> 1));
         if ($signed((SB+1)'(p)) - half < 0) v = '0;
         else if ($signed((SB+1)'(p)) + half >= $signed((SB+1)'(lim)))
            v = $signed((SB+1)'(lim)) - $signed((SB+1)'(win)) - 1;
         else v = $signed((SB+1)'(p)) - half;
         if (v < 0) v = '0;
         centre = v[COORD_BITS-1:0];
      end
   endfunction

   function automatic logic [COORD_BITS+SIZE_BITS-1:0] grow(
      input logic [COORD_BITS-1:0] s, input logic [SIZE_BITS-1:0] l,
      input logic [SIZE_BITS-1:0] lim);
      logic [COORD_BITS-1:0] ns;
      logic [SIZE_BITS-1:0] nl;
      logic [SB:0] t;
      begin
         if (s >= COORD_BITS'(GROW_BIG)) ns = s - COORD_BITS'(GROW_BIG);
         else if (s != '0) ns = s - 1'b1;
         else ns = '0;
         t = (SB+1)'(l) + (SB+1)'(ns);
         if (t + (SB+1)'(GROW_BIG2) < (SB+1)'(lim)) nl = l + SIZE_BITS'(GROW_BIG2);
         else if (t + 1'b1 < (SB+1)'(lim)) nl = l + 1'b1;
         else nl = l;
         grow = {ns, nl};
      end
   endfunction

   always_comb begin
      det = hit_ff && (wt_ff >= WEIGHT_BITS'(wthr_ff)) && (wt_ff != '0);
      npx = (qc_ff < SUM_BITS'(fw_ff)) ? qc_ff[COORD_BITS-1:0]
                                       : COORD_BITS'(fw_ff >> 1);
      npy = (qr_ff < SUM_BITS'(fh_ff)) ? qr_ff[COORD_BITS-1:0]
                                       : COORD_BITS'(fh_ff >> 1);
      nleft = centre(npx, fw_ff, win_ff);
      ntop = centre(npy, fh_ff, win_ff);
      {gleft, gw} = grow(left_ff, sw_ff, fw_ff);
      {gtop, gh} = grow(top_ff, sh_ff, fh_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_c_ff <= '0;
         sum_r_ff <= '0;
         wt_ff <= '0;
         hit_ff <= 1'b0;
         left_ff <= '0;
         top_ff <= '0;
         sw_ff <= '0;
         sh_ff <= '0;
         px_ff <= '0;
         py_ff <= '0;
         found_ff <= 1'b0;
      end else if (cmd.accum && qualify) begin
         sum_c_ff <= sum_c_ff + col_w;
         sum_r_ff <= sum_r_ff + row_w;
         wt_ff <= wt_sum[WEIGHT_BITS-1:0];
         hit_ff <= 1'b1;
      end else if (cmd.finish) begin
         found_ff <= det;
         if (det) begin
            px_ff <= npx;
            py_ff <= npy;
            left_ff <= nleft;
            top_ff <= ntop;
            sw_ff <= win_ff;
            sh_ff <= win_ff;
         end else begin
            left_ff <= gleft;
            top_ff <= gtop;
            sw_ff <= gw;
            sh_ff <= gh;
         end
         sum_c_ff <= '0;
         sum_r_ff <= '0;
         wt_ff <= '0;
         hit_ff <= 1'b0;
      end
   end

   assign found = found_ff;
   assign point_x = px_ff;
   assign point_y = py_ff;
   assign region_x = left_ff;
   assign region_y = top_ff;
   assign region_width = sw_ff;
   assign region_height = sh_ff;
endmodule

@@ hw/rtl/windowed_color_centroid_tracker_unit.sv @@
// Colour centroid tracker.
// The req_ channel carries one pixel per transaction: coordinates, three
// colour channels, a hue byte and a frame_end flag. While idle, pixels are
// taken back to back; qualifying ones update the weighted sums of the region.
// A pixel with frame_end set starts the frame-end work: two 64-bit divisions
// by the total weight run side by side on restoring dividers, one quotient
// bit per cycle; the controller then finishes and raises rsp_valid. The
// result holds until rsp_ready is seen; while it waits, and during the
// division, req_ready is low, so a stalled receiver stalls the pixel stream.
// The next pixel can be taken in the cycle after the result is accepted.
// The csr_ port writes configuration registers; index 0 to 6 select mask
// threshold, hue centre, hue tolerance, window size, frame width, frame
// height and weight threshold. Write only while idle.
// Reset loads the default configuration, clears the sums and leaves an
// empty search region, so the first frame only grows the region.
module windowed_color_centroid_tracker_unit #(
   parameter int COORD_BITS = wcct_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [wcct_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [wcct_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [COORD_BITS-1:0]               req_col,
   input  logic [COORD_BITS-1:0]               req_row,
   input  logic [7:0]                          req_chan_blue,
   input  logic [7:0]                          req_chan_green,
   input  logic [7:0]                          req_chan_red,
   input  logic [7:0]                          req_hue_value,
   input  logic                                req_frame_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [COORD_BITS-1:0]               rsp_point_x,
   output logic [COORD_BITS-1:0]               rsp_point_y,
   output logic [COORD_BITS-1:0]               rsp_region_x,
   output logic [COORD_BITS-1:0]               rsp_region_y,
   output logic [wcct_pkg::SIZE_BITS-1:0]      rsp_region_width,
   output logic [wcct_pkg::SIZE_BITS-1:0]      rsp_region_height
);
   import wcct_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   wcct_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts(sts), .cmd(cmd)
   );

   wcct_dp #(.COORD_BITS(COORD_BITS)) u_dp (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data,
      .col(req_col), .row(req_row), .chan_blue(req_chan_blue),
      .chan_green(req_chan_green), .chan_red(req_chan_red),
      .hue_value(req_hue_value), .frame_end(req_frame_end),
      .cmd(cmd), .sts(sts),
      .found(rsp_found), .point_x(rsp_point_x), .point_y(rsp_point_y),
      .region_x(rsp_region_x), .region_y(rsp_region_y),
      .region_width(rsp_region_width), .region_height(rsp_region_height)
   );
endmodule

@@ hw/rtl/wcct_checker.sv @@
module wcct_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_frame_end,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_found
);
   // A result is only ever waiting while no pixel can enter.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("pixel accepted while a result is pending");

   // An ordinary pixel never produces a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_frame_end) |=> !rsp_valid)
      else $error("result without frame end");

   // After a frame end is taken, req_ready is checked to be low.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_frame_end) |=> !req_ready)
      else $error("pixel accepted during frame-end processing");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_found)))
      else $error("stalled result changed");
endmodule

bind windowed_color_centroid_tracker_unit wcct_checker u_wcct_checker (
   .clock, .reset, .req_valid, .req_ready, .req_frame_end,
   .rsp_valid, .rsp_ready, .rsp_found
);
